/* design/csv_byte_parser_sjis_macros.svh */
// Assertion macros shared by the parser modules.
`ifndef CSV_BYTE_PARSER_SJIS_MACROS_SVH
`define CSV_BYTE_PARSER_SJIS_MACROS_SVH

`ifndef SYNTHESIS

// Check a property every clock edge outside reset.
`define CSVS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed: %m");

// Check a property every clock edge, reset included.
`define CSVS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed: %m");

`else

`define CSVS_ASSERT(lbl, clk, rst_n, prop)
`define CSVS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* design/csvs_pkg.sv */
`default_nettype none

package csvs_pkg;

    localparam int ROW_W   = 10;
    localparam int COL_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int MB_W    = 2;

    localparam int MAX_ROWS        = 1024;
    localparam int MAX_COLUMNS     = 64;
    localparam int MAX_FIELD_BYTES = 256;

    localparam int ROW_CAP_I  = (MAX_ROWS - 1) < 1023 ? (MAX_ROWS - 1) : 1023;
    localparam int COL_CAP_I  = (MAX_COLUMNS - 1) < 63 ? (MAX_COLUMNS - 1) : 63;
    localparam int BYTE_CAP_I = (MAX_FIELD_BYTES - 1) < 255 ? (MAX_FIELD_BYTES - 1) : 255;

    localparam logic [ROW_W-1:0]  ROW_CAP  = ROW_W'(ROW_CAP_I);
    localparam logic [COL_W-1:0]  COL_CAP  = COL_W'(COL_CAP_I);
    localparam logic [BYTE_W-1:0] BYTE_CAP = BYTE_W'(BYTE_CAP_I);

    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIELD = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ROW   = 2'd3;

    localparam logic [MB_W-1:0] MB_SINGLE = 2'd0;
    localparam logic [MB_W-1:0] MB_LEAD   = 2'd1;
    localparam logic [MB_W-1:0] MB_TRAIL  = 2'd2;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NL    = 8'h0A;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        data_byte;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
        logic [BYTE_W-1:0] offset;
        logic              overflow;
    } t_result;

    function automatic logic is_lead(input logic [7:0] b);
        return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
    endfunction

    function automatic logic is_trail(input logic [7:0] b);
        return (b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC);
    endfunction

endpackage

`default_nettype wire

/* design/csv_byte_parser_sjis.sv */
`default_nettype none

// CSV byte parser with Shift-JIS awareness. Accepts one text byte per cycle
// and returns exactly one result per byte: data byte with its row, column and
// in-field offset, field end on a comma, row end on a newline, or nothing for
// a consumed quote. Bytes of two-byte Shift-JIS characters always pass as data;
// only single-byte characters act as delimiters, and a doubled quote inside
// quotes yields one data quote. Row, column and offset saturate and set a
// sticky overflow flag that only reset clears. Throughput is one byte per
// clock while o_stall is low; each result is registered into a two-entry
// output buffer when its byte is accepted, so bytes keep flowing while one
// result waits, and o_stall rises only once both entries are held.

module csv_byte_parser_sjis
    import csvs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [7:0]        i_text_byte,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [KIND_W-1:0]      o_kind,
    output logic [7:0]             o_data_byte,
    output logic [ROW_W-1:0]       o_row,
    output logic [COL_W-1:0]       o_column,
    output logic [BYTE_W-1:0]      o_offset,
    output logic                   o_overflow
);

    logic    take;
    logic    full;
    t_result res_in;
    t_result res_out;

    assign o_stall = full;
    assign take    = i_valid && !full;

    csvs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_text_byte (i_text_byte),
        .o_res       (res_in)
    );

    csvs_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_res   (res_in),
        .o_full  (full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (res_out)
    );

    assign o_kind      = res_out.kind;
    assign o_data_byte = res_out.data_byte;
    assign o_row       = res_out.row;
    assign o_column    = res_out.column;
    assign o_offset    = res_out.offset;
    assign o_overflow  = res_out.overflow;

endmodule

`default_nettype wire

/* design/csvs_core.sv */
`default_nettype none
`include "csv_byte_parser_sjis_macros.svh"

module csvs_core
    import csvs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_text_byte,
    output t_result         o_res
);

    logic [MB_W-1:0]   r_mb,     n_mb;
    logic              r_inq,    n_inq;
    logic              r_fstart, n_fstart;
    logic [ROW_W-1:0]  r_row,    n_row;
    logic [COL_W-1:0]  r_col,    n_col;
    logic [BYTE_W-1:0] r_bytes,  n_bytes;
    logic              r_ovf,    n_ovf;

    always_comb begin
        logic [KIND_W-1:0] kind;
        logic              q;
        logic              inq_t;
        logic              ovf_hit;

        n_inq    = r_inq;
        n_fstart = r_fstart;
        n_row    = r_row;
        n_col    = r_col;
        n_bytes  = r_bytes;
        kind     = KIND_NONE;
        ovf_hit  = 1'b0;
        q        = (i_text_byte == CH_QUOTE);
        inq_t    = r_inq ^ q;

        unique case (r_mb)
            MB_SINGLE: n_mb = is_lead(i_text_byte)  ? MB_LEAD  : MB_SINGLE;
            MB_LEAD:   n_mb = is_trail(i_text_byte) ? MB_TRAIL : MB_SINGLE;
            MB_TRAIL:  n_mb = is_lead(i_text_byte)  ? MB_LEAD  : MB_SINGLE;
            default:   n_mb = MB_SINGLE;
        endcase

        if (n_mb != MB_SINGLE) begin
            kind     = KIND_DATA;
            n_fstart = 1'b0;
        end else begin
            n_inq = inq_t;
            if (inq_t) begin
                // an opening quote at field start is consumed
                kind     = (!q || !r_fstart) ? KIND_DATA : KIND_NONE;
                n_fstart = 1'b0;
            end else if (i_text_byte == CH_COMMA) begin
                kind     = KIND_FIELD;
                n_bytes  = '0;
                n_fstart = 1'b1;
                if (r_col >= COL_CAP) begin
                    n_col   = COL_CAP;
                    ovf_hit = 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end else if (i_text_byte == CH_NL) begin
                kind     = KIND_ROW;
                n_col    = '0;
                n_bytes  = '0;
                n_fstart = 1'b1;
                if (r_row >= ROW_CAP) begin
                    n_row   = ROW_CAP;
                    ovf_hit = 1'b1;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end else begin
                kind     = q ? KIND_NONE : KIND_DATA;
                n_fstart = 1'b0;
            end
        end

        if (kind == KIND_DATA) begin
            if (r_bytes >= BYTE_CAP) begin
                n_bytes = BYTE_CAP;
                ovf_hit = 1'b1;
            end else begin
                n_bytes = r_bytes + 1'b1;
            end
        end

        n_ovf = r_ovf | ovf_hit;

        o_res.kind      = kind;
        o_res.data_byte = (kind == KIND_DATA) ? i_text_byte : 8'd0;
        o_res.row       = r_row;
        o_res.column    = r_col;
        o_res.offset    = r_bytes;
        o_res.overflow  = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mb     <= MB_SINGLE;
            r_inq    <= 1'b0;
            r_fstart <= 1'b1;
            r_row    <= '0;
            r_col    <= '0;
            r_bytes  <= '0;
            r_ovf    <= 1'b0;
        end else if (i_take) begin
            r_mb     <= n_mb;
            r_inq    <= n_inq;
            r_fstart <= n_fstart;
            r_row    <= n_row;
            r_col    <= n_col;
            r_bytes  <= n_bytes;
            r_ovf    <= n_ovf;
        end
    end

    `CSVS_ASSERT(a_field_end_restarts, i_clk, i_rst_n,
        i_rst_n && i_take && o_res.kind == KIND_FIELD |=> r_fstart && r_bytes == '0)
    `CSVS_ASSERT(a_row_end_clears, i_clk, i_rst_n,
        i_rst_n && i_take && o_res.kind == KIND_ROW |=> r_col == '0 && r_bytes == '0)
    `CSVS_ASSERT_ALWAYS(a_overflow_sticky, i_clk,
        r_ovf && i_rst_n |=> r_ovf)
    `CSVS_ASSERT(a_data_counts, i_clk, i_rst_n,
        i_rst_n && i_take && o_res.kind == KIND_DATA && r_bytes < BYTE_CAP
        |=> r_bytes == $past(r_bytes) + 1'b1)

endmodule

`default_nettype wire

/* design/csvs_obuf.sv */
`default_nettype none
`include "csv_byte_parser_sjis_macros.svh"

module csvs_obuf
    import csvs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_res,
    output logic         o_full,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_res
);

    t_result    r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       pop;

    assign pop     = o_valid && !i_stall;
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_res   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            unique case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    `CSVS_ASSERT(a_no_push_when_full, i_clk, i_rst_n, !(i_push && o_full))
    `CSVS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count != 2'd3)
    `CSVS_ASSERT(a_pop_drains, i_clk, i_rst_n,
        i_rst_n && pop && !i_push |=> r_count == $past(r_count) - 2'd1)

endmodule

`default_nettype wire

/* tb/csv_byte_parser_sjis_tb.sv */
module csv_byte_parser_sjis_tb;
    import csvs_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [7:0]        i_text_byte = 8'h00;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [KIND_W-1:0] o_kind;
    logic [7:0]        o_data_byte;
    logic [ROW_W-1:0]  o_row;
    logic [COL_W-1:0]  o_column;
    logic [BYTE_W-1:0] o_offset;
    logic              o_overflow;

    logic [7:0] text_queue[$];
    t_result    parse_due[$];
    logic       byte_taken = 1'b0;
    logic       send_hold = 1'b0;
    int         idle_pct = 0;
    int         stall_pct = 0;
    int         mismatch_count = 0;

    // shadow parser state, starts at its reset values
    logic [MB_W-1:0]   mb_state = MB_SINGLE;
    logic              in_quotes = 1'b0;
    logic              field_start = 1'b1;
    logic [ROW_W-1:0]  row_cnt = '0;
    logic [COL_W-1:0]  col_cnt = '0;
    logic [BYTE_W-1:0] byte_cnt = '0;
    logic              ovf_seen = 1'b0;

    logic [7:0] opening_text [28] = '{
        CH_QUOTE, 8'h61, CH_QUOTE, CH_QUOTE, CH_COMMA, CH_QUOTE, CH_COMMA,
        CH_QUOTE, CH_QUOTE, CH_NL, 8'h62, CH_QUOTE, 8'h78, CH_QUOTE, CH_COMMA,
        8'h81, 8'h40, 8'h9F, 8'h7E, 8'hE0, 8'h80, 8'hFC, 8'hFC, 8'h81, 8'h2C,
        8'h00, 8'hFF, CH_NL
    };

    csv_byte_parser_sjis dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_text_byte (i_text_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte),
        .o_row       (o_row),
        .o_column    (o_column),
        .o_offset    (o_offset),
        .o_overflow  (o_overflow)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int sat_inc(int value, int cap);
        if (value >= cap) begin
            ovf_seen = 1'b1;
            return cap;
        end
        return value + 1;
    endfunction

    function automatic t_result parse_byte(logic [7:0] b);
        t_result res;
        logic    lead;
        logic    trail;
        lead  = (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
        trail = (b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC);
        res.kind      = KIND_NONE;
        res.data_byte = 8'h00;
        res.row       = row_cnt;
        res.column    = col_cnt;
        res.offset    = byte_cnt;

        if (mb_state == MB_SINGLE && lead) begin
            mb_state = MB_LEAD;
        end else if (mb_state == MB_LEAD && trail) begin
            mb_state = MB_TRAIL;
        end else if (mb_state == MB_TRAIL && lead) begin
            mb_state = MB_LEAD;
        end else begin
            mb_state = MB_SINGLE;
        end

        if (mb_state != MB_SINGLE) begin
            res.kind    = KIND_DATA;
            field_start = 1'b0;
        end else begin
            if (b == CH_QUOTE) begin
                in_quotes = !in_quotes;
            end
            if (in_quotes) begin
                // a quote reopening after a close is a literal quote
                if (b != CH_QUOTE || !field_start) begin
                    res.kind = KIND_DATA;
                end
                field_start = 1'b0;
            end else if (b == CH_COMMA) begin
                res.kind    = KIND_FIELD;
                col_cnt     = COL_W'(sat_inc(int'(col_cnt), int'(COL_CAP)));
                byte_cnt    = '0;
                field_start = 1'b1;
            end else if (b == CH_NL) begin
                res.kind    = KIND_ROW;
                row_cnt     = ROW_W'(sat_inc(int'(row_cnt), int'(ROW_CAP)));
                col_cnt     = '0;
                byte_cnt    = '0;
                field_start = 1'b1;
            end else begin
                if (b != CH_QUOTE) begin
                    res.kind = KIND_DATA;
                end
                field_start = 1'b0;
            end
        end

        if (res.kind == KIND_DATA) begin
            res.data_byte = b;
            byte_cnt      = BYTE_W'(sat_inc(int'(byte_cnt), int'(BYTE_CAP)));
        end
        res.overflow = ovf_seen;
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic logic [7:0] lead_byte();
        return $urandom_range(0, 1) ? 8'($urandom_range(8'h81, 8'h9F))
                                    : 8'($urandom_range(8'hE0, 8'hFC));
    endfunction

    function automatic logic [7:0] trail_byte();
        return $urandom_range(0, 1) ? 8'($urandom_range(8'h40, 8'h7E))
                                    : 8'($urandom_range(8'h80, 8'hFC));
    endfunction

    // one CSV row of random fields; quotes always come in pairs so that
    // later rows still see real delimiters
    task automatic add_record();
        int         n_fields;
        int         len;
        int         style;
        logic [7:0] b;
        n_fields = $urandom_range(1, 5);
        for (int f = 0; f < n_fields; f++) begin
            if (f != 0) begin
                text_queue.push_back(CH_COMMA);
            end
            len   = $urandom_range(0, 6);
            style = $urandom_range(0, 9);
            if (style < 3) begin
                for (int k = 0; k < len; k++) begin
                    text_queue.push_back(8'($urandom_range(8'h30, 8'h7A)));
                end
                if (len != 0 && $urandom_range(0, 5) == 0) begin
                    text_queue.push_back(CH_QUOTE);
                    text_queue.push_back(8'h41);
                    text_queue.push_back(CH_COMMA);
                    text_queue.push_back(CH_QUOTE);
                end
            end else if (style < 6) begin
                text_queue.push_back(CH_QUOTE);
                for (int k = 0; k < len; k++) begin
                    case ($urandom_range(0, 5))
                        0: begin
                            text_queue.push_back(CH_QUOTE);
                            text_queue.push_back(CH_QUOTE);
                        end
                        1: text_queue.push_back(CH_COMMA);
                        2: text_queue.push_back(CH_NL);
                        3: text_queue.push_back(lead_byte());
                        default: text_queue.push_back(8'($urandom_range(8'h23, 8'h7E)));
                    endcase
                end
                text_queue.push_back(CH_QUOTE);
            end else if (style < 8) begin
                for (int k = 0; k < len; k++) begin
                    text_queue.push_back(lead_byte());
                    text_queue.push_back(trail_byte());
                end
            end else if (style == 8) begin
                for (int k = 0; k < len; k++) begin
                    case ($urandom_range(0, 2))
                        0: text_queue.push_back(lead_byte());
                        1: text_queue.push_back(trail_byte());
                        default: text_queue.push_back(8'($urandom_range(8'h30, 8'h7A)));
                    endcase
                end
            end else begin
                for (int k = 0; k < len; k++) begin
                    do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
                    text_queue.push_back(b);
                end
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            text_queue.push_back(8'h0D);
        end
        text_queue.push_back(CH_NL);
    endtask

    task automatic fill_records(int count);
        int target;
        target = text_queue.size() + count;
        while (text_queue.size() < target) begin
            add_record();
        end
    endtask

    task automatic drain_text();
        while (text_queue.size() != 0) @(negedge i_clk);
    endtask

    task automatic settle();
        while (i_valid || parse_due.size() != 0) @(negedge i_clk);
    endtask

    // driver: hold a request until taken, then advance or idle
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
            if (!i_valid || byte_taken) begin
                if (!send_hold && text_queue.size() != 0 &&
                    $urandom_range(0, 99) >= idle_pct) begin
                    i_valid     <= 1'b1;
                    i_text_byte <= text_queue.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check the result leaving now, then predict the request taken now
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (parse_due.size() == 0) begin
                    $error("result with no request pending: kind %0d", o_kind);
                    mismatch_count++;
                end else begin
                    want = parse_due.pop_front();
                    check_field("kind", want.kind, o_kind);
                    check_field("data_byte", want.data_byte, o_data_byte);
                    check_field("row", want.row, o_row);
                    check_field("column", want.column, o_column);
                    check_field("offset", want.offset, o_offset);
                    check_field("overflow", want.overflow, o_overflow);
                end
            end
            byte_taken <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                parse_due.push_back(parse_byte(i_text_byte));
            end
        end
    end

    initial begin
        #3000000;
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_text[k]) begin
            text_queue.push_back(opening_text[k]);
        end
        drain_text();

        fill_records(130);
        drain_text();

        idle_pct = 81;
        fill_records(130);
        repeat (100) @(negedge i_clk);
        // hold the sender until the parser has nothing left in flight
        send_hold = 1'b1;
        settle();
        repeat (20) @(negedge i_clk);
        send_hold = 1'b0;
        drain_text();

        idle_pct  = 0;
        stall_pct = 81;
        fill_records(130);
        drain_text();

        idle_pct  = 20;
        stall_pct = 20;
        fill_records(130);
        drain_text();

        // saturate offset and column counters in turn
        idle_pct  = 0;
        stall_pct = 0;
        settle();
        if (in_quotes) begin
            text_queue.push_back(CH_QUOTE);
        end
        repeat (260) text_queue.push_back(8'h61);
        repeat (66) text_queue.push_back(CH_COMMA);
        repeat (2) text_queue.push_back(CH_NL);
        text_queue.push_back(8'h7A);
        drain_text();

        settle();
        repeat (10) @(negedge i_clk);
        if (mismatch_count == 0 && parse_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
